>>> rtl/core/ptp_pkg.sv
// Package for the homogeneous point transform with perspective divide.
// Holds widths and register indexes; no dependencies.
`default_nettype none
package ptp_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DW = 32;
	localparam int CFG_W = 64;
	localparam int NUM_REGS = 8;
	localparam int IDX_W = 3;
	localparam int SUM_W = 68;
	localparam int MAG_W = 64;

	typedef enum logic [IDX_W-1:0] {
		REG_ROW0_C01 = 3'd0, REG_ROW0_C23 = 3'd1,
		REG_ROW1_C01 = 3'd2, REG_ROW1_C23 = 3'd3,
		REG_ROW2_C01 = 3'd4, REG_ROW2_C23 = 3'd5,
		REG_ROW3_C01 = 3'd6, REG_ROW3_C23 = 3'd7
	} reg_idx_t;
endpackage
`default_nettype wire

>>> rtl/core/ptp_mac.sv
// Matrix stages: exact products, then column sums and magnitudes.
// Depends on ptp_pkg.
`default_nettype none
module ptp_mac #(
	parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic v_in,
	input  wire logic signed [ptp_pkg::DW-1:0] px,
	input  wire logic signed [ptp_pkg::DW-1:0] py,
	input  wire logic signed [ptp_pkg::DW-1:0] pz,
	input  wire logic [ptp_pkg::CFG_W-1:0] regs [ptp_pkg::NUM_REGS],
	output logic v_out,
	output logic [ptp_pkg::MAG_W-1:0] num_mag [3],
	output logic [2:0] num_neg,
	output logic [ptp_pkg::MAG_W-1:0] den_mag,
	output logic den_neg
);
	localparam int SW = ptp_pkg::SUM_W;
	localparam int MAG_W = ptp_pkg::MAG_W;
	logic signed [63:0] prod_s1 [4][3];
	logic signed [SW-1:0] trans_s1 [4];
	logic v_s1, v_s2;
	logic signed [SW-1:0] sum_c [4];

	function automatic logic signed [31:0] elem(input logic [ptp_pkg::CFG_W-1:0] r [8],
		input int row, input int col);
		logic [63:0] w;
		begin
			w = r[row*2 + col/2];
			return (col % 2 == 1) ? w[63:32] : w[31:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[c][0] <= px * elem(regs, 0, c);
				prod_s1[c][1] <= py * elem(regs, 1, c);
				prod_s1[c][2] <= pz * elem(regs, 2, c);
				trans_s1[c] <= SW'(elem(regs, 3, c)) <<< FRAC_BITS;
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++)
			sum_c[c] = trans_s1[c] + SW'(prod_s1[c][0]) + SW'(prod_s1[c][1])
				+ SW'(prod_s1[c][2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				num_neg[c] <= sum_c[c][SW-1];
				num_mag[c] <= sum_c[c][SW-1] ? MAG_W'(-sum_c[c]) : MAG_W'(sum_c[c]);
			end
			den_neg <= sum_c[3][SW-1];
			den_mag <= sum_c[3][SW-1] ? MAG_W'(-sum_c[3]) : MAG_W'(sum_c[3]);
		end
	end

	assign v_out = v_s2;
endmodule
`default_nettype wire

>>> rtl/core/ptp_div.sv
// Pipelined restoring divider: one quotient bit per stage after the setup stage, saturating result.
// Depends on ptp_pkg.
`default_nettype none
module ptp_div #(
	parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic v_in,
	input  wire logic [ptp_pkg::MAG_W-1:0] num,
	input  wire logic nneg,
	input  wire logic [ptp_pkg::MAG_W-1:0] den,
	input  wire logic dneg,
	output logic v_out,
	output logic signed [ptp_pkg::DW-1:0] quo
);
	// Quotient bits above bit 32 mean saturation; only the low 33 are
	// developed, the rest are caught by a compare on the top numerator part.
	localparam int MW = ptp_pkg::MAG_W;
	localparam int NW = MW + FRAC_BITS;
	localparam int QB = 33;
	localparam int ST = QB + 1;
	localparam int RW = MW + 1;

	logic           v_p   [ST];
	logic [RW-1:0]  rem_p [ST];
	logic [QB-1:0]  q_p   [ST];
	logic [NW-1:0]  n_p   [ST];
	logic [MW-1:0]  d_p   [ST];
	logic           neg_p [ST];
	logic           big_p [ST];
	logic [NW-1:0]  nfull;
	logic [RW-1:0]  trial [QB];
	logic [31:0]    lim;
	logic [QB-1:0]  qf;

	assign nfull = {num, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ST; i++) v_p[i] <= 1'b0;
		end else if (en) begin
			v_p[0] <= v_in;
			for (int i = 1; i < ST; i++) v_p[i] <= v_p[i-1];
		end
	end

	always_comb begin
		for (int i = 0; i < QB; i++)
			trial[i] = {rem_p[i][MW-1:0], n_p[i][QB-1-i]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// High part of numerator >= den means quotient >= 2^33.
			rem_p[0] <= RW'(nfull[NW-1:QB]);
			big_p[0] <= MW'(nfull[NW-1:QB]) >= den;
			q_p[0]   <= '0;
			n_p[0]   <= nfull;
			d_p[0]   <= den;
			neg_p[0] <= nneg ^ dneg;
			for (int i = 0; i < QB; i++) begin
				if (trial[i] >= RW'(d_p[i])) begin
					rem_p[i+1] <= trial[i] - RW'(d_p[i]);
					q_p[i+1]   <= {q_p[i][QB-2:0], 1'b1};
				end else begin
					rem_p[i+1] <= trial[i];
					q_p[i+1]   <= {q_p[i][QB-2:0], 1'b0};
				end
				n_p[i+1]   <= n_p[i];
				d_p[i+1]   <= d_p[i];
				neg_p[i+1] <= neg_p[i];
				big_p[i+1] <= big_p[i];
			end
		end
	end

	assign qf  = q_p[ST-1];
	assign lim = neg_p[ST-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;

	always_comb begin
		logic [31:0] m;
		m = (big_p[ST-1] || qf[QB-1] || qf[31:0] > lim) ? lim : qf[31:0];
		quo = neg_p[ST-1] ? -m : m;
	end

	assign v_out = v_p[ST-1];
endmodule
`default_nettype wire

>>> rtl/core/point_transform_perspective_core.sv
// Top level of the point transform with perspective divide.
// Depends on ptp_pkg, ptp_mac and ptp_div.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  input   | in_valid / in_ready  | in_x, in_y, in_z
//  output  | out_valid / out_ready| out_x, out_y, out_z, w_zero
//  config  | cfg_we               | cfg_idx, cfg_data (8 x 64 bit)
//
// One point a clock unless the output stalls. Stages: 2 matrix (multiply,
// sum), 34 divider (setup, then one quotient bit each), output register.
// Reset loads the identity matrix and clears every valid bit.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module point_transform_perspective_core #(
	parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic signed [ptp_pkg::DW-1:0] in_x,
	input  wire logic signed [ptp_pkg::DW-1:0] in_y,
	input  wire logic signed [ptp_pkg::DW-1:0] in_z,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic signed [ptp_pkg::DW-1:0] out_x,
	output logic signed [ptp_pkg::DW-1:0] out_y,
	output logic signed [ptp_pkg::DW-1:0] out_z,
	output logic      w_zero,
	input  wire logic cfg_we,
	input  wire logic [ptp_pkg::IDX_W-1:0] cfg_idx,
	input  wire logic [ptp_pkg::CFG_W-1:0] cfg_data
);
	localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

	logic [ptp_pkg::CFG_W-1:0] regs_q [ptp_pkg::NUM_REGS];
	logic en;
	logic v_mac;
	logic [ptp_pkg::MAG_W-1:0] nmag [3];
	logic [2:0] nneg;
	logic [ptp_pkg::MAG_W-1:0] dmag;
	logic dneg;
	logic [2:0] v_div;
	logic signed [ptp_pkg::DW-1:0] q [3];
	logic wz_p [34];

	// Advance whenever the output slot is free or being taken.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Matrix registers; reset to identity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[ptp_pkg::REG_ROW0_C01] <= {32'd0, ONE};
			regs_q[ptp_pkg::REG_ROW0_C23] <= '0;
			regs_q[ptp_pkg::REG_ROW1_C01] <= {ONE, 32'd0};
			regs_q[ptp_pkg::REG_ROW1_C23] <= '0;
			regs_q[ptp_pkg::REG_ROW2_C01] <= '0;
			regs_q[ptp_pkg::REG_ROW2_C23] <= {32'd0, ONE};
			regs_q[ptp_pkg::REG_ROW3_C01] <= '0;
			regs_q[ptp_pkg::REG_ROW3_C23] <= {ONE, 32'd0};
		end else if (cfg_we) begin
			regs_q[cfg_idx] <= cfg_data;
		end
	end

	ptp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk, .arst_n, .en, .v_in(in_valid),
		.px(in_x), .py(in_y), .pz(in_z), .regs(regs_q),
		.v_out(v_mac), .num_mag(nmag), .num_neg(nneg),
		.den_mag(dmag), .den_neg(dneg)
	);

	for (genvar c = 0; c < 3; c++) begin : g_div
		ptp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk, .arst_n, .en, .v_in(v_mac),
			.num(nmag[c]), .nneg(nneg[c]), .den(dmag), .dneg(dneg),
			.v_out(v_div[c]), .quo(q[c])
		);
	end

	// Carry the zero-w flag alongside the divider stages.
	always_ff @(posedge clk) begin
		if (en) begin
			wz_p[0] <= (dmag == '0);
			for (int i = 1; i < 34; i++) wz_p[i] <= wz_p[i-1];
		end
	end

	// Output register: hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_div[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_zero <= wz_p[33];
			out_x  <= wz_p[33] ? '0 : q[0];
			out_y  <= wz_p[33] ? '0 : q[1];
			out_z  <= wz_p[33] ? '0 : q[2];
		end
	end
endmodule
`default_nettype wire
